/* src/spf_pkg.sv */
package spf_pkg;

  localparam int VALUE_W       = 14;
  localparam int EXP_W         = 4;
  localparam int DEF_MAX_VALUE = 16383;
  localparam int VALUE_TOP     = (1 << VALUE_W) - 1;

  localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

  // the table never needs to reach past what the input port can carry
  function automatic int table_top(input int max_value);
    return (max_value < VALUE_TOP) ? max_value : VALUE_TOP;
  endfunction

endpackage

/* src/spf_table.sv */
module spf_table #(
  parameter int MAX_VALUE = spf_pkg::DEF_MAX_VALUE,
  parameter int AW        = $clog2(spf_pkg::table_top(MAX_VALUE) + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data,
  output logic          ready
);
  import spf_pkg::*;

  localparam int TOP = table_top(MAX_VALUE);
  localparam logic [AW-1:0] TOP_I = AW'(TOP);
  localparam logic [AW:0]   TOP_J = (AW + 1)'(TOP);
  localparam logic [AW-1:0] TWO   = AW'(2);

  logic [AW-1:0] mem [TOP+1];

  logic [AW-1:0] i;
  logic [AW:0]   j;
  logic [AW:0]   j_next;

  // sieve runs divisors downward and always writes, so the smallest
  // divisor of each entry is the last one to land there
  assign j_next = j + {1'b0, i};

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
      i     <= TOP_I;
      j     <= TOP_J;
    end else if (!ready) begin
      if (j_next > TOP_J) begin
        if (i == TWO) begin
          ready <= 1'b1;
        end else begin
          i <= i - 1'b1;
          j <= {1'b0, i - 1'b1};
        end
      end else begin
        j <= j_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ready && !rst) begin
      mem[j[AW-1:0]] <= i;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  a_ready_holds: assert property (@(posedge clk) disable iff (rst)
    ready |=> ready)
    else $error("table ready dropped");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    !ready |-> (j <= TOP_J && i >= TWO))
    else $error("sieve pointer out of range");

endmodule

/* src/spf_div.sv */
module spf_div #(
  parameter int W = spf_pkg::VALUE_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  import spf_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  r;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // restoring division, one quotient bit per cycle
  assign shifted  = {r, q[W-1]};
  assign trial    = shifted - {1'b0, d};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r <= '0;
      q <= dividend;
      d <= divisor;
    end else if (busy) begin
      if (trial[W]) begin
        r <= shifted[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end else begin
        r <= trial[W-1:0];
        q <= {q[W-2:0], 1'b1};
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

endmodule

/* src/sieve_prime_factorizer.sv */
// Prime factorizer backed by a smallest-prime-factor table.
// After reset the table is filled by a sieve over every value up to MAX_VALUE
// (capped at the input range); in_stall stays high during the fill, which writes
// each multiple of every divisor, running the divisors down from the top to 2.
// Input channel: value, accepted when in_valid is high and in_stall low.
// Output channel: prime, exponent, last, none; one transaction per distinct
// prime in ascending order, last set on the final one. Values 0, 1 and values
// beyond MAX_VALUE give one transaction with none and last set, prime and
// exponent zero.
// One value is worked at a time. Each prime power costs a table read, a check
// and one pass of the shared restoring divider over AW quotient bits (AW = 14
// at the default bound). The divider is the limiting unit.
// Results leave through an output register: a stalled receiver holds the
// current transaction and the block waits for the register to free before
// loading the next; the next value is accepted while the last result waits.
module sieve_prime_factorizer #(
  parameter int MAX_VALUE = spf_pkg::DEF_MAX_VALUE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spf_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spf_pkg::VALUE_W-1:0] prime,
  output logic [spf_pkg::EXP_W-1:0]   exponent,
  output logic                        last,
  output logic                        none
);
  import spf_pkg::*;

  localparam int TOP = table_top(MAX_VALUE);
  localparam int AW  = $clog2(TOP + 1);
  localparam logic [VALUE_W-1:0] TOP_V = VALUE_W'(TOP);
  localparam logic [VALUE_W-1:0] TWO_V = VALUE_W'(2);
  localparam logic [AW-1:0]      TWO_A = AW'(2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state;
  logic             have_p;
  logic [AW-1:0]    rem;
  logic [AW-1:0]    cur_p;
  logic [EXP_W-1:0] exp_cnt;
  logic             em_last;
  logic             em_none;

  logic             tbl_ready;
  logic [AW-1:0]    rd_data;
  logic             new_prime;
  logic             div_start;
  logic [AW-1:0]    div_divisor;
  logic             div_done;
  logic [AW-1:0]    div_quot;
  logic             out_free;

  spf_table #(.MAX_VALUE(MAX_VALUE), .AW(AW)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == S_READ),
    .rd_addr (rem),
    .rd_data (rd_data),
    .ready   (tbl_ready)
  );

  spf_div #(.W(AW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_stall    = (state != S_IDLE) || !tbl_ready;
  assign out_free    = !out_valid || !out_stall;
  // a different smallest factor closes the current prime group
  assign new_prime   = have_p && (rd_data != cur_p);
  assign div_start   = (state == S_CHECK) && (rem >= TWO_A) && !new_prime;
  assign div_divisor = have_p ? cur_p : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      have_p    <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && tbl_ready) begin
            if (value < TWO_V || value > TOP_V) begin
              em_last <= 1'b1;
              em_none <= 1'b1;
              cur_p   <= '0;
              exp_cnt <= '0;
              state   <= S_EMIT;
            end else begin
              rem     <= value[AW-1:0];
              have_p  <= 1'b0;
              em_none <= 1'b0;
              state   <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rem < TWO_A) begin
            em_last <= 1'b1;
            state   <= S_EMIT;
          end else if (new_prime) begin
            em_last <= 1'b0;
            state   <= S_EMIT;
          end else begin
            if (!have_p) begin
              cur_p   <= rd_data;
              exp_cnt <= '0;
              have_p  <= 1'b1;
            end
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rem <= div_quot;
            if (exp_cnt != EXP_MAX) begin
              exp_cnt <= exp_cnt + 1'b1;
            end
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            have_p <= 1'b0;
            state  <= em_last ? S_IDLE : S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      prime    <= VALUE_W'(cur_p);
      exponent <= exp_cnt;
      last     <= em_last;
      none     <= em_none;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("transaction accepted but sequencer stayed idle");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none) |-> (last && prime == '0 && exponent == '0))
    else $error("none result malformed");

  a_div_has_prime: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (have_p && cur_p >= TWO_A))
    else $error("dividing without a valid prime");

endmodule
